/* rtl/retro_vm_instruction_core_macros.svh */
// Assertion macros shared by the checker of the instruction core.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef RETRO_VM_INSTRUCTION_CORE_MACROS_SVH
`define RETRO_VM_INSTRUCTION_CORE_MACROS_SVH

// same-cycle implication
`define RVM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("instruction core check failed");

// next-cycle implication
`define RVM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("instruction core check failed");

`endif

/* rtl/rvm_pkg.sv */
// Types, constants and the font table of the instruction core.
// No dependencies; used by the interfaces, the core and its checker.
package rvm_pkg;

	localparam int MEM_BYTES_D     = 4096;
	localparam int SCREEN_WIDTH_D  = 64;
	localparam int SCREEN_HEIGHT_D = 32;
	localparam int STACK_DEPTH_D   = 16;

	localparam int ADDR_W     = 12;
	localparam int READ_W     = 64;
	localparam int FONT_BYTES = 80;

	localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
	localparam logic [ADDR_W-1:0] FONT_BASE   = 12'h050;
	localparam logic [ADDR_W-1:0] INDEX_SEL   = 12'd16;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_EXEC = 2'd1,
		MODE_ROW  = 2'd2,
		MODE_REG  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_WAIT, ST_HI, ST_LO, ST_VX, ST_VY, ST_EXEC,
		ST_WRAP, ST_DMEM, ST_DXOR, ST_FLAG, ST_DONE
	} state_t;

	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEB  = 4'h3;
	localparam logic [3:0] OP_SNEB = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDB  = 4'h6;
	localparam logic [3:0] OP_ADDB = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] SYS_CLS   = 8'hE0;
	localparam logic [7:0] SYS_RET   = 8'hEE;
	localparam logic [7:0] MISC_GDT  = 8'h07;
	localparam logic [7:0] MISC_SDT  = 8'h15;
	localparam logic [7:0] MISC_SST  = 8'h18;
	localparam logic [7:0] MISC_ADDI = 8'h1E;

	localparam logic [3:0] FLAG_REG = 4'hF;

	localparam logic [8*FONT_BYTES-1:0] FONT = {
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] font_byte(input logic [6:0] i);
		return FONT[8*(FONT_BYTES-1-int'(i)) +: 8];
	endfunction

endpackage

/* rtl/rvm_if.sv */
// Request and response channels of the instruction core.
// Depends on rvm_pkg.
interface rvm_req_if import rvm_pkg::*; ();
	logic               valid;
	logic               ready;
	mode_t              mode;
	logic [ADDR_W-1:0]  address;
	logic [7:0]         data;

	modport source (output valid, mode, address, data, input ready);
	modport sink (input valid, mode, address, data, output ready);
endinterface

interface rvm_rsp_if import rvm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [READ_W-1:0]  read_data;
	logic [ADDR_W-1:0]  next_pc;
	logic               screen_changed;
	logic               status;

	modport source (output valid, read_data, next_pc, screen_changed, status, input ready);
	modport sink (input valid, read_data, next_pc, screen_changed, status, output ready);
endinterface

/* rtl/rvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/retro_vm_instruction_core.sv */
// Top level of the CHIP-8 style instruction core.
// Depends on rvm_pkg, rvm_req_if/rvm_rsp_if and rvm_ram.
//
// One item at a time. After reset the core copies the 80-byte font into program
// memory, one byte a cycle, and takes no item until the copy is done. A memory
// load goes straight to the done state, a screen row or register read through a
// wait state, and a plain instruction through a fetch of two bytes, then reads of
// VX, VY and the stack, all through one read port each, then execute. A sprite
// draw adds coordinate wrap steps and, per drawn row, a read and write-back of the
// screen memory. A finished result waits in an output register while the
// next item is taken.
module retro_vm_instruction_core import rvm_pkg::*; #(
	parameter int MEM_BYTES     = MEM_BYTES_D,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_D,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_D,
	parameter int STACK_DEPTH   = STACK_DEPTH_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_address_we,
	input  logic [ADDR_W-1:0] start_address,
	rvm_req_if.sink           req,
	rvm_rsp_if.source         rsp
);
	localparam int MAW  = $clog2(MEM_BYTES);
	localparam int RW   = $clog2(SCREEN_HEIGHT);
	localparam int SPW  = $clog2(STACK_DEPTH);
	localparam int SW   = SCREEN_WIDTH;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] pc_q, idx_q, addr_q;
	logic [SPW-1:0]    sp_q;
	logic [7:0]        dt_q, snd_q;
	logic [7:0]        hi_q, lo_q, vx_q, sx_q, sy_q, flag_q;
	logic [ADDR_W-1:0] stk_q;
	logic [3:0]        r_q;
	logic [RW-1:0]     srow_q;
	logic [6:0]        fill_q;
	logic              rvok_q, sok_q;
	logic [15:0]       rvalid_q;
	logic [SCREEN_HEIGHT-1:0] svalid_q;
	mode_t             mode_q;
	logic [READ_W-1:0] rd_q;
	logic              chg_q, stat_q;

	logic              out_valid_q, out_chg_q, out_stat_q;
	logic [READ_W-1:0] out_rd_q;
	logic [ADDR_W-1:0] out_pc_q;

	logic              accept, out_free;

	// memory ports
	logic              m_we;
	logic [MAW-1:0]    m_waddr, m_raddr;
	logic [7:0]        m_wdata, m_rdata;
	logic              r_we;
	logic [3:0]        r_waddr, r_raddr;
	logic [7:0]        r_wdata, r_rdata;
	logic              s_we;
	logic [RW-1:0]     s_raddr;
	logic [SW-1:0]     s_wdata, s_rdata;
	logic              k_we;
	logic [SPW-1:0]    k_raddr;
	logic [ADDR_W-1:0] k_rdata;

	// decode
	logic [3:0]        op, x, y, n;
	logic [ADDR_W-1:0] nnn, pc2, skip;
	logic [SPW-1:0]    sp_inc, sp_dec;
	logic [7:0]        vreg, vy;

	// execute
	logic              x_we, f_we, bad, cls, call, ret, idx_we, dt_we, snd_we;
	logic [7:0]        x_val, f_val;
	logic [ADDR_W-1:0] pc_n, idx_val;
	logic [8:0]        sum9;

	// draw
	logic [8:0]        row_sum;
	logic              draw_stop, wrap_done;
	logic [SW+7:0]     spread;
	logic [SW-1:0]     mask, old_row;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign rsp.valid          = out_valid_q;
	assign rsp.read_data      = out_rd_q;
	assign rsp.next_pc        = out_pc_q;
	assign rsp.screen_changed = out_chg_q;
	assign rsp.status         = out_stat_q;

	assign op   = hi_q[7:4];
	assign x    = hi_q[3:0];
	assign y    = lo_q[7:4];
	assign n    = lo_q[3:0];
	assign nnn  = {x, lo_q};
	assign pc2  = pc_q + ADDR_W'(2);
	assign skip = pc_q + ADDR_W'(4);
	assign sp_inc = (sp_q == SPW'(STACK_DEPTH-1)) ? '0 : sp_q + SPW'(1);
	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH-1) : sp_q - SPW'(1);
	assign vreg   = rvok_q ? r_rdata : 8'h00;
	// VY arrives from the register RAM in the execute cycle
	assign vy     = vreg;
	assign sum9   = {1'b0, vx_q} + {1'b0, vy};

	assign row_sum   = {1'b0, sy_q} + 9'(r_q);
	assign draw_stop = (r_q == n) || (row_sum >= 9'(SCREEN_HEIGHT));
	assign wrap_done = (sx_q < 8'(SW)) && (sy_q < 8'(SCREEN_HEIGHT));
	assign spread    = {m_rdata, SW'(0)} >> sx_q;
	assign mask      = spread[SW+7:8];
	assign old_row   = sok_q ? s_rdata : '0;

	rvm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_prog_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	rvm_ram #(.WIDTH(8), .DEPTH(16)) u_reg_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	rvm_ram #(.WIDTH(SW), .DEPTH(SCREEN_HEIGHT)) u_screen_ram (
		.clk(clk), .we(s_we), .waddr(srow_q), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	rvm_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk(clk), .we(k_we), .waddr(sp_q), .wdata(pc2),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	always_comb begin
		x_we = 1'b0; x_val = vy; f_we = 1'b0; f_val = 8'h00;
		pc_n = pc2; bad = 1'b0; cls = 1'b0; call = 1'b0; ret = 1'b0;
		idx_we = 1'b0; idx_val = nnn; dt_we = 1'b0; snd_we = 1'b0;
		unique case (op)
			OP_SYS: begin
				if (lo_q == SYS_CLS) begin
					cls = 1'b1;
				end else if (lo_q == SYS_RET) begin
					ret = 1'b1;
					pc_n = stk_q;
				end else begin
					bad = 1'b1;
				end
			end
			OP_JP: pc_n = nnn;
			OP_CALL: begin
				call = 1'b1;
				pc_n = nnn;
			end
			OP_SEB:  if (vx_q == lo_q) pc_n = skip;
			OP_SNEB: if (vx_q != lo_q) pc_n = skip;
			OP_SER:  if (vx_q == vy) pc_n = skip;
			OP_SNER: if (vx_q != vy) pc_n = skip;
			OP_LDB: begin
				x_we = 1'b1;
				x_val = lo_q;
			end
			OP_ADDB: begin
				x_we = 1'b1;
				x_val = vx_q + lo_q;
			end
			OP_ALU: begin
				x_we = 1'b1;
				unique case (n)
					ALU_MOV: x_val = vy;
					ALU_OR:  x_val = vx_q | vy;
					ALU_AND: x_val = vx_q & vy;
					ALU_XOR: x_val = vx_q ^ vy;
					ALU_ADD: begin
						x_val = sum9[7:0];
						f_we = 1'b1;
						f_val = {7'b0, sum9[8]};
					end
					ALU_SUB: begin
						x_val = vx_q - vy;
						f_we = 1'b1;
						f_val = {7'b0, vx_q >= vy};
					end
					ALU_SHR: begin
						x_val = {1'b0, vy[7:1]};
						f_we = 1'b1;
						f_val = {7'b0, vy[0]};
					end
					ALU_SBN: begin
						x_val = vy - vx_q;
						f_we = 1'b1;
						f_val = {7'b0, vy >= vx_q};
					end
					ALU_SHL: begin
						x_val = {vy[6:0], 1'b0};
						f_we = 1'b1;
						f_val = {7'b0, vy[7]};
					end
					default: begin
						x_we = 1'b0;
						bad = 1'b1;
					end
				endcase
			end
			OP_LDI: idx_we = 1'b1;
			OP_DRW: f_we = 1'b1;
			OP_MISC: begin
				unique case (lo_q)
					MISC_GDT: begin
						x_we = 1'b1;
						x_val = dt_q;
					end
					MISC_SDT: dt_we = 1'b1;
					MISC_SST: snd_we = 1'b1;
					MISC_ADDI: begin
						idx_we = 1'b1;
						idx_val = idx_q + ADDR_W'(vx_q);
					end
					default: bad = 1'b1;
				endcase
			end
			default: bad = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: if (fill_q == 7'(FONT_BYTES-1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (req.mode)
						MODE_LOAD: state_d = ST_DONE;
						MODE_EXEC: state_d = ST_HI;
						default:   state_d = ST_WAIT;
					endcase
				end
			end
			ST_WAIT: state_d = ST_DONE;
			ST_HI:   state_d = ST_LO;
			ST_LO:   state_d = ST_VX;
			ST_VX:   state_d = ST_VY;
			ST_VY:   state_d = ST_EXEC;
			ST_EXEC: begin
				if (op == OP_DRW) state_d = ST_WRAP;
				else if (f_we)    state_d = ST_FLAG;
				else              state_d = ST_DONE;
			end
			ST_WRAP: if (wrap_done) state_d = ST_DMEM;
			ST_DMEM: state_d = draw_stop ? ST_FLAG : ST_DXOR;
			ST_DXOR: state_d = ST_DMEM;
			ST_FLAG: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		m_we = 1'b0; m_waddr = req.address; m_wdata = req.data; m_raddr = pc_q;
		r_we = 1'b0; r_waddr = x; r_wdata = x_val; r_raddr = req.address[3:0];
		s_we = 1'b0; s_wdata = old_row ^ mask; s_raddr = req.address[RW-1:0];
		k_we = 1'b0; k_raddr = sp_dec;
		unique case (state_q)
			ST_INIT: begin
				m_we = 1'b1;
				m_waddr = FONT_BASE + ADDR_W'(fill_q);
				m_wdata = font_byte(fill_q);
			end
			ST_IDLE: m_we = accept && (req.mode == MODE_LOAD);
			ST_LO:   m_raddr = pc_q + ADDR_W'(1);
			ST_VX:   r_raddr = x;
			ST_VY:   r_raddr = y;
			ST_EXEC: begin
				r_we = x_we;
				k_we = call;
			end
			ST_DMEM: begin
				m_raddr = idx_q + ADDR_W'(r_q);
				s_raddr = row_sum[RW-1:0];
			end
			ST_DXOR: s_we = 1'b1;
			ST_FLAG: begin
				r_we = 1'b1;
				r_waddr = FLAG_REG;
				r_wdata = flag_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			fill_q      <= '0;
			pc_q        <= START_RESET;
			idx_q       <= '0;
			sp_q        <= '0;
			dt_q        <= '0;
			snd_q       <= '0;
			rvalid_q    <= '0;
			svalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_address_we) begin
				pc_q <= start_address;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: fill_q <= fill_q + 7'd1;
				ST_EXEC: begin
					if (x_we) rvalid_q[x] <= 1'b1;
					if (cls) svalid_q <= '0;
					if (call) sp_q <= sp_inc;
					if (ret) sp_q <= sp_dec;
					if (idx_we) idx_q <= idx_val;
					if (dt_we) dt_q <= vx_q;
					if (snd_we) snd_q <= vx_q;
					pc_q <= pc_n;
				end
				ST_DXOR: svalid_q[srow_q] <= 1'b1;
				ST_FLAG: rvalid_q[FLAG_REG] <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q <= req.mode;
				addr_q <= req.address;
				rd_q   <= '0;
				chg_q  <= 1'b0;
				stat_q <= 1'b0;
				rvok_q <= rvalid_q[req.address[3:0]];
				sok_q  <= (req.address < ADDR_W'(SCREEN_HEIGHT)) &&
					svalid_q[req.address[RW-1:0]];
			end
			ST_WAIT: begin
				if (mode_q == MODE_ROW) begin
					rd_q <= sok_q ? (READ_W'(s_rdata) << (READ_W - SW)) : '0;
				end else if (addr_q < INDEX_SEL) begin
					rd_q <= READ_W'(vreg);
				end else if (addr_q == INDEX_SEL) begin
					rd_q <= READ_W'(idx_q);
				end
			end
			ST_LO: hi_q <= m_rdata;
			ST_VX: begin
				lo_q   <= m_rdata;
				rvok_q <= rvalid_q[x];
			end
			ST_VY: begin
				vx_q   <= vreg;
				stk_q  <= k_rdata;
				rvok_q <= rvalid_q[y];
			end
			ST_EXEC: begin
				stat_q <= bad;
				chg_q  <= cls || (op == OP_DRW);
				flag_q <= f_val;
				sx_q   <= vx_q;
				sy_q   <= vy;
				r_q    <= '0;
			end
			ST_WRAP: begin
				if (sx_q >= 8'(SW)) sx_q <= sx_q - 8'(SW);
				if (sy_q >= 8'(SCREEN_HEIGHT)) sy_q <= sy_q - 8'(SCREEN_HEIGHT);
			end
			ST_DMEM: begin
				srow_q <= row_sum[RW-1:0];
				sok_q  <= svalid_q[row_sum[RW-1:0]];
			end
			ST_DXOR: begin
				flag_q[0] <= flag_q[0] | (|(old_row & mask));
				r_q <= r_q + 4'd1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_rd_q   <= rd_q;
					out_pc_q   <= pc_q;
					out_chg_q  <= chg_q;
					out_stat_q <= stat_q;
				end
			end
			default: ;
		endcase
	end
endmodule

/* rtl/rvm_checker.sv */
// Port-level assertions for the instruction core and their bind.
// Depends on rvm_pkg and retro_vm_instruction_core_macros.svh.
`include "retro_vm_instruction_core_macros.svh"

module rvm_checker import rvm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [READ_W-1:0] rsp_read_data,
	input logic              rsp_changed,
	input logic              rsp_status
);
	`RVM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`RVM_ASSERT_NEXT(a_one_word, req_valid && req_ready, !req_ready)
	`RVM_ASSERT_NOW(a_bad_no_draw, rsp_valid && rsp_status, !rsp_changed)
	`RVM_ASSERT_NOW(a_draw_no_data, rsp_valid && rsp_changed, rsp_read_data == '0)
	`RVM_ASSERT_NOW(a_bad_no_data, rsp_valid && rsp_status, rsp_read_data == '0)
endmodule

bind retro_vm_instruction_core rvm_checker u_rvm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_read_data(rsp.read_data),
	.rsp_changed(rsp.screen_changed),
	.rsp_status(rsp.status)
);

/* tb/retro_vm_instruction_core_tb.sv */
// Testbench of the instruction core: loads programs byte by byte, executes them and
// checks every response against a built-in predictor of the core.
// Depends on rvm_pkg, rvm_req_if/rvm_rsp_if and the core.
`timescale 1ns / 1ps

module retro_vm_instruction_core_tb;
	import rvm_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [READ_W-1:0] read_data;
		logic [ADDR_W-1:0] next_pc;
		logic              screen_changed;
		logic              status;
	} core_result_t;

	class core_scoreboard;
		logic [7:0]        mem [MEM_BYTES_D];
		bit                mem_set [MEM_BYTES_D];
		logic [63:0]       screen [SCREEN_HEIGHT_D];
		logic [7:0]        vreg [16];
		logic [ADDR_W-1:0] index_reg;
		logic [ADDR_W-1:0] pc;
		logic [ADDR_W-1:0] ret_stack [STACK_DEPTH_D];
		bit                ret_set [STACK_DEPTH_D];
		logic [3:0]        sp;
		logic [7:0]        delay_cnt;
		logic [7:0]        sound_cnt;
		core_result_t      pending [$];
		int                errors;

		function new();
			for (int i = 0; i < MEM_BYTES_D; i++) begin
				mem[i] = 8'h00;
				mem_set[i] = 0;
			end
			for (int i = 0; i < FONT_BYTES; i++) begin
				mem[int'(FONT_BASE) + i] = FONT[8*(FONT_BYTES-1-i) +: 8];
				mem_set[int'(FONT_BASE) + i] = 1;
			end
			foreach (screen[i]) screen[i] = '0;
			foreach (vreg[i]) vreg[i] = '0;
			foreach (ret_stack[i]) begin
				ret_stack[i] = '0;
				ret_set[i] = 0;
			end
			index_reg = '0;
			pc = START_RESET;
			sp = '0;
			delay_cnt = '0;
			sound_cnt = '0;
			errors = 0;
		endfunction

		function void set_start(logic [ADDR_W-1:0] v);
			pc = v;
		endfunction

		function bit ret_ok();
			return ret_set[sp - 4'd1];
		endfunction

		// a draw only reads sprite bytes for rows above the bottom edge
		function bit sprite_ok(logic [3:0] n, logic [7:0] vy);
			for (int r = 0; r < int'(n); r++) begin
				if (int'(vy[4:0]) + r >= SCREEN_HEIGHT_D) break;
				if (!mem_set[index_reg + ADDR_W'(r)]) return 0;
			end
			return 1;
		endfunction

		function bit exec_safe();
			logic [7:0] hi, lo;
			if (!mem_set[pc] || !mem_set[pc + 12'd1]) return 0;
			hi = mem[pc];
			lo = mem[pc + 12'd1];
			if (hi[7:4] == OP_SYS && lo == SYS_RET && !ret_ok()) return 0;
			if (hi[7:4] == OP_DRW && !sprite_ok(lo[3:0], vreg[lo[7:4]])) return 0;
			return 1;
		endfunction

		function void execute(output logic changed, output logic bad);
			logic [7:0] hi, lo, vx, vy, bits, hit;
			logic [3:0] x, y, n;
			logic [ADDR_W-1:0] npc, skp, nnn;
			logic [8:0] sum;
			int sx, sy, row, col;
			hi = mem[pc];
			lo = mem[pc + 12'd1];
			x = hi[3:0];
			y = lo[7:4];
			n = lo[3:0];
			nnn = {x, lo};
			vx = vreg[x];
			vy = vreg[y];
			npc = pc + 12'd2;
			skp = pc + 12'd4;
			changed = 0;
			bad = 0;
			case (hi[7:4])
				OP_SYS: begin
					if (lo == SYS_CLS) begin
						foreach (screen[i]) screen[i] = '0;
						changed = 1;
					end else if (lo == SYS_RET) begin
						sp = sp - 4'd1;
						npc = ret_stack[sp];
					end else bad = 1;
				end
				OP_JP: npc = nnn;
				OP_CALL: begin
					ret_stack[sp] = npc;
					ret_set[sp] = 1;
					sp = sp + 4'd1;
					npc = nnn;
				end
				OP_SEB: if (vx == lo) npc = skp;
				OP_SNEB: if (vx != lo) npc = skp;
				OP_SER: if (vx == vy) npc = skp;
				OP_SNER: if (vx != vy) npc = skp;
				OP_LDB: vreg[x] = lo;
				OP_ADDB: vreg[x] = vx + lo;
				OP_ALU: begin
					case (n)
						ALU_MOV: vreg[x] = vy;
						ALU_OR:  vreg[x] = vx | vy;
						ALU_AND: vreg[x] = vx & vy;
						ALU_XOR: vreg[x] = vx ^ vy;
						ALU_ADD: begin
							sum = {1'b0, vx} + {1'b0, vy};
							vreg[x] = sum[7:0];
							vreg[FLAG_REG] = {7'd0, sum[8]};
						end
						ALU_SUB: begin
							vreg[x] = vx - vy;
							vreg[FLAG_REG] = {7'd0, vx >= vy};
						end
						ALU_SHR: begin
							vreg[x] = vy >> 1;
							vreg[FLAG_REG] = {7'd0, vy[0]};
						end
						ALU_SBN: begin
							vreg[x] = vy - vx;
							vreg[FLAG_REG] = {7'd0, vy >= vx};
						end
						ALU_SHL: begin
							vreg[x] = vy << 1;
							vreg[FLAG_REG] = {7'd0, vy[7]};
						end
						default: bad = 1;
					endcase
				end
				OP_LDI: index_reg = nnn;
				OP_DRW: begin
					sx = int'(vx[5:0]);
					sy = int'(vy[4:0]);
					hit = 8'd0;
					for (int r = 0; r < int'(n); r++) begin
						row = sy + r;
						if (row >= SCREEN_HEIGHT_D) break;
						bits = mem[index_reg + ADDR_W'(r)];
						for (int c = 0; c < 8; c++) begin
							col = sx + c;
							if (col >= SCREEN_WIDTH_D) break;
							if (bits[7-c]) begin
								if (screen[row][63-col]) hit = 8'd1;
								screen[row][63-col] = ~screen[row][63-col];
							end
						end
					end
					vreg[FLAG_REG] = hit;
					changed = 1;
				end
				OP_MISC: begin
					case (lo)
						MISC_GDT:  vreg[x] = delay_cnt;
						MISC_SDT:  delay_cnt = vx;
						MISC_SST:  sound_cnt = vx;
						MISC_ADDI: index_reg = index_reg + {4'd0, vx};
						default:   bad = 1;
					endcase
				end
				default: bad = 1;
			endcase
			pc = npc;
		endfunction

		function void note(mode_t mode, logic [ADDR_W-1:0] addr, logic [7:0] data);
			core_result_t res;
			res.read_data = '0;
			res.screen_changed = 0;
			res.status = 0;
			case (mode)
				MODE_LOAD: begin
					mem[addr] = data;
					mem_set[addr] = 1;
				end
				MODE_EXEC: execute(res.screen_changed, res.status);
				MODE_ROW: if (addr < SCREEN_HEIGHT_D) res.read_data = screen[addr];
				default: begin
					if (addr < 16) res.read_data = {56'd0, vreg[addr[3:0]]};
					else if (addr == INDEX_SEL) res.read_data = {52'd0, index_reg};
				end
			endcase
			res.next_pc = pc;
			pending.push_back(res);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("%0t: %s got %h, want %h", $realtime, what, got, want);
		endtask

		task check(core_result_t got);
			core_result_t want;
			if (pending.size() == 0) begin
				report("unexpected word, next_pc", got.next_pc, 0);
				return;
			end
			want = pending.pop_front();
			if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
			if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
			if (got.screen_changed !== want.screen_changed)
				report("screen_changed", got.screen_changed, want.screen_changed);
			if (got.status !== want.status) report("status", got.status, want.status);
		endtask
	endclass

	logic clk, arst_n, start_address_we;
	logic [ADDR_W-1:0] start_address;
	rvm_req_if req ();
	rvm_rsp_if rsp ();
	core_scoreboard sb;
	int idle_cycles, sent, rx_gap, rx_count;

	retro_vm_instruction_core dut (
		.clk(clk), .arst_n(arst_n), .start_address_we(start_address_we),
		.start_address(start_address), .req(req.sink), .rsp(rsp.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			rx_gap <= 0;
			rx_count <= 0;
		end else begin
			rx_count <= rx_count + 1;
			if (rx_gap > 0) begin
				rsp.ready <= 0;
				rx_gap <= rx_gap - 1;
			end else begin
				rsp.ready <= 1;
				rx_gap <= pick_gap((rx_count / 500) % 4 == 1);
			end
		end
	end

	always @(posedge clk) begin
		core_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.read_data = rsp.read_data;
			got.next_pc = rsp.next_pc;
			got.screen_changed = rsp.screen_changed;
			got.status = rsp.status;
			sb.check(got);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task send(mode_t mode, logic [ADDR_W-1:0] addr, logic [7:0] data);
		int gap;
		gap = pick_gap((sent / 200) % 5 == 2);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.mode <= mode;
		req.address <= addr;
		req.data <= data;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note(mode, addr, data);
		sent++;
	endtask

	task drain();
		req.valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task write_start(logic [ADDR_W-1:0] v);
		drain();
		start_address_we <= 1;
		start_address <= v;
		@(posedge clk);
		start_address_we <= 0;
		sb.set_start(v);
		@(posedge clk);
	endtask

	// place any unset sprite bytes of a draw, then the two instruction bytes, then execute it
	task run_op(logic [15:0] op);
		logic [ADDR_W-1:0] a, at;
		logic [3:0] n;
		at = sb.pc;
		if (op[15:12] == OP_DRW) begin
			n = op[3:0];
			for (int r = 0; r < int'(n); r++) begin
				a = sb.index_reg + ADDR_W'(r);
				if (!sb.mem_set[a] && a != at && a != at + 12'd1)
					send(MODE_LOAD, a, 8'($urandom_range(0, 255)));
			end
		end
		send(MODE_LOAD, at, op[15:8]);
		send(MODE_LOAD, at + 12'd1, op[7:0]);
		send(MODE_EXEC, '0, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [15:0] rand_op();
		int k;
		logic [3:0] x, y;
		logic [7:0] b;
		logic [11:0] nnn;
		logic [15:0] op;
		logic [7:0] fsel [4];
		fsel = '{MISC_GDT, MISC_SDT, MISC_SST, MISC_ADDI};
		k = $urandom_range(0, 99);
		x = 4'($urandom_range(0, 15));
		y = 4'($urandom_range(0, 15));
		b = 8'($urandom_range(0, 255));
		nnn = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4080, 4095))
			: 12'($urandom_range(0, 4095));
		if (k < 4) op = {OP_SYS, 4'h0, SYS_CLS};
		else if (k < 10) op = sb.ret_ok() ? {OP_SYS, 4'h0, SYS_RET} : {OP_CALL, nnn};
		else if (k < 13) op = {OP_SYS, x, b};
		else if (k < 19) op = {OP_JP, nnn};
		else if (k < 25) op = {OP_CALL, nnn};
		else if (k < 30) op = {OP_SEB, x, $urandom_range(0, 1) ? sb.vreg[x] : b};
		else if (k < 34) op = {OP_SNEB, x, $urandom_range(0, 1) ? sb.vreg[x] : b};
		else if (k < 38) op = {OP_SER, x, y, b[3:0]};
		else if (k < 42) op = {OP_SNER, x, y, b[3:0]};
		else if (k < 54) op = {OP_LDB, x, b};
		else if (k < 60) op = {OP_ADDB, x, b};
		else if (k < 76) begin
			if ($urandom_range(0, 4) == 0) op = {OP_ALU, x, y, b[3:0]};
			else if ($urandom_range(0, 8) == 0) op = {OP_ALU, x, y, ALU_SHL};
			else op = {OP_ALU, x, y, 1'b0, b[2:0]};
		end
		else if (k < 81) op = {OP_LDI, nnn};
		else if (k < 90) op = {OP_DRW, x, y, ($urandom_range(0, 5) == 0) ? b[3:0] : {2'b00, b[1:0]}};
		else if (k < 96) op = {OP_MISC, x, $urandom_range(0, 3) ? fsel[b[1:0]] : b};
		else op = {4'($urandom_range(11, 14)), x, b};
		if (op[15:12] == OP_SYS && op[7:0] == SYS_RET && !sb.ret_ok())
			op = {OP_SYS, 4'h0, SYS_CLS};
		return op;
	endfunction

	task random_phase(int count);
		int first, k;
		first = sent;
		while (sent - first < count) begin
			k = $urandom_range(0, 99);
			if ($urandom_range(0, 199) == 0) drain();
			if (k < 70) run_op(rand_op());
			else if (k < 80) send(MODE_LOAD, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
			else if (k < 86) send(MODE_ROW, ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
				: 12'($urandom_range(0, 35)), 8'($urandom_range(0, 255)));
			else if (k < 92) send(MODE_REG, ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
				: 12'($urandom_range(0, 17)), 8'($urandom_range(0, 255)));
			else if (sb.exec_safe()) send(MODE_EXEC, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		idle_cycles = 0;
		arst_n = 0;
		start_address_we = 0;
		start_address = START_RESET;
		req.valid = 0;
		req.mode = MODE_LOAD;
		req.address = '0;
		req.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_start(START_RESET);
		send(MODE_REG, 12'd0, 8'h00);
		send(MODE_REG, INDEX_SEL, 8'hFF);
		send(MODE_REG, 12'd17, 8'h00);
		send(MODE_REG, 12'hFFF, 8'h00);
		send(MODE_ROW, 12'd31, 8'h00);
		send(MODE_ROW, 12'd32, 8'h00);
		send(MODE_LOAD, 12'hFFF, 8'hFF);
		send(MODE_LOAD, 12'h000, 8'h00);
		run_op(16'h60FF);
		run_op(16'h6101);
		run_op(16'h8F14);
		run_op(16'h60FF);
		run_op(16'h8014);
		run_op(16'h8015);
		run_op(16'h8017);
		run_op(16'h8016);
		run_op(16'h801E);
		run_op(16'h00E0);
		run_op(16'hA050);
		run_op(16'hD015);
		run_op(16'hD015);
		run_op(16'h603F);
		run_op(16'h611F);
		run_op(16'hD01F);
		run_op(16'hD000);
		run_op(16'h2300);
		run_op(16'h00EE);
		run_op(16'h1400);
		run_op(16'h30FF);
		run_op(16'h40FF);
		run_op(16'h5010);
		run_op(16'h9010);
		run_op(16'hF015);
		run_op(16'hF018);
		run_op(16'hF207);
		run_op(16'hF01E);
		run_op(16'h0123);
		run_op(16'h8018);
		run_op(16'hB123);
		run_op(16'hC1FF);
		run_op(16'hE09E);
		run_op(16'hF029);
		run_op(16'hF0FF);
		write_start(12'hFFF);
		run_op(16'h6A5A);
		run_op(16'h1FFE);

		random_phase(350);
		write_start(12'h000);
		random_phase(350);
		write_start(12'($urandom_range(0, 4095)));
		random_phase(350);
		write_start(12'hFFF);
		random_phase(350);

		drain();
		if (sb.errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
